// File: design/sps_pkg.sv
// shared constants, codes and phase tables for the stepper phase sequencer
`default_nettype none

package sps_pkg;

    // counter width default
    localparam int COUNT_WIDTH_DEF = 16;

    // field widths
    localparam int LEVEL_W    = 10;
    localparam int IDX_W      = 5;
    localparam int WAIT_W     = 14;
    localparam int STEPCNT_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    localparam logic [LEVEL_W-1:0] LEVEL_ON  = 10'd1000;
    localparam logic [LEVEL_W-1:0] LEVEL_OFF = 10'd0;

    // operation codes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // step modes
    localparam logic [1:0] MODE_WAVE  = 2'd0;
    localparam logic [1:0] MODE_FULL  = 2'd1;
    localparam logic [1:0] MODE_HALF  = 2'd2;
    localparam logic [1:0] MODE_MICRO = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCKWISE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_INTERVAL = 2'd2;

    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [IDX_W-1:0]   idx_t;

    localparam logic [3:0] WAVE_TAB = 4'b0001;   // bit i is entry i
    localparam logic [3:0] FULL_TAB = 4'b0011;
    localparam logic [7:0] HALF_TAB = 8'b0000_0111;

    localparam level_t MICRO_TAB [32] = '{
        10'd500, 10'd625, 10'd750, 10'd875, 10'd1000, 10'd875, 10'd750, 10'd625,
        10'd500, 10'd375, 10'd250, 10'd125, 10'd0,    10'd0,   10'd0,   10'd0,
        10'd0,   10'd0,   10'd0,   10'd0,   10'd0,    10'd0,   10'd0,   10'd0,
        10'd0,   10'd0,   10'd0,   10'd0,   10'd0,    10'd125, 10'd250, 10'd375
    };

    localparam logic [1:0] WAVE_OFF_CW  [4] = '{2'd0, 2'd2, 2'd3, 2'd1};
    localparam logic [1:0] WAVE_OFF_CCW [4] = '{2'd0, 2'd2, 2'd1, 2'd3};
    localparam logic [1:0] FULL_OFF_CW  [4] = '{2'd1, 2'd3, 2'd0, 2'd2};
    localparam logic [1:0] FULL_OFF_CCW [4] = '{2'd0, 2'd2, 2'd1, 2'd3};
    localparam logic [2:0] HALF_OFF     [4] = '{3'd0, 3'd4, 3'd2, 3'd6};
    localparam idx_t       MICRO_OFF    [4] = '{5'd0, 5'd16, 5'd8, 5'd24};

    // level of one coil for a mode, direction and phase index
    function automatic level_t phase_level(input logic [1:0] mode, input logic cw,
                                           input logic [1:0] coil, input idx_t idx);
        logic [1:0] p4;
        logic [2:0] p8;
        idx_t       p32;
        level_t     lv;
        p4  = '0;
        p8  = '0;
        p32 = '0;
        case (mode)
            MODE_WAVE:
            begin
                p4 = (cw ? WAVE_OFF_CW[coil] : WAVE_OFF_CCW[coil]) + idx[1:0];
                lv = WAVE_TAB[p4] ? LEVEL_ON : LEVEL_OFF;
            end
            MODE_FULL:
            begin
                p4 = (cw ? FULL_OFF_CW[coil] : FULL_OFF_CCW[coil]) + idx[1:0];
                lv = FULL_TAB[p4] ? LEVEL_ON : LEVEL_OFF;
            end
            MODE_HALF:
            begin
                p8 = HALF_OFF[coil] + idx[2:0];
                lv = HALF_TAB[p8] ? LEVEL_ON : LEVEL_OFF;
            end
            default:
            begin
                p32 = MICRO_OFF[coil] + idx;
                lv  = MICRO_TAB[p32];
            end
        endcase
        return lv;
    endfunction

endpackage

`default_nettype wire

// File: design/stepper_phase_sequencer_unit.sv
// top level of the four-coil stepper phase sequencer
`default_nettype none

// channel   | direction | handshake           | payload
// ----------+-----------+---------------------+-----------------------------------------
// input     | in        | in_valid / in_stall | operation, step_count
// result    | out       | out_valid/out_stall | coil_a..d_level, step_strobe, busy_res
// config    | in        | cfg_we              | cfg_index, cfg_data
//
// one beat in, one beat out; each beat's result is registered after the update logic,
// and one beat per cycle is sustained while the result side keeps up
// results sit in an output register backed by a one-entry skid register, so a
// new beat is taken while a result waits; input stalls only when both are full
// reset clears control state and the sequencer state and sets the config registers to defaults

module stepper_phase_sequencer_unit
    import sps_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,

    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [1:0]             operation,
    input  wire logic [STEPCNT_W-1:0]   step_count,

    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [LEVEL_W-1:0]          coil_a_level,
    output logic [LEVEL_W-1:0]          coil_b_level,
    output logic [LEVEL_W-1:0]          coil_c_level,
    output logic [LEVEL_W-1:0]          coil_d_level,
    output logic                        step_strobe,
    output logic                        busy_res
);

    // wide enough to compare the 16-bit count against the counter maximum
    localparam int EXT_W = (COUNT_WIDTH > STEPCNT_W) ? COUNT_WIDTH : STEPCNT_W;
    localparam logic [EXT_W-1:0] CNT_MAX = EXT_W'({COUNT_WIDTH{1'b1}});

    typedef struct packed {
        level_t [3:0] levels;
        logic         strobe;
        logic         busy;
    } result_t;

    // configuration registers
    logic [1:0]        step_mode_reg;
    logic              clockwise_reg;
    logic [WAIT_W-1:0] step_interval_reg;

    // sequencer state
    idx_t                   phase_index_reg, phase_index_next;
    logic [COUNT_WIDTH-1:0] steps_left_reg,  steps_left_next;
    logic [WAIT_W-1:0]      wait_count_reg,  wait_count_next;
    logic                   moving_reg,      moving_next;
    level_t [3:0]           coil_levels_reg, coil_levels_next;

    // result buffering
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    result_t result;

    logic in_fire;
    logic out_free;

    logic [EXT_W-1:0]  cnt_ext;
    logic [WAIT_W-1:0] lim;
    logic [WAIT_W:0]   wait_inc;
    logic              strobe;

    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // config writes, unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_mode_reg     <= MODE_WAVE;
            clockwise_reg     <= 1'b1;
            step_interval_reg <= WAIT_W'(100);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STEP_MODE:     step_mode_reg     <= cfg_data[1:0];
                CFG_CLOCKWISE:     clockwise_reg     <= cfg_data[0];
                CFG_STEP_INTERVAL: step_interval_reg <= cfg_data[WAIT_W-1:0];
                default:           ;
            endcase
        end
    end

    // per-beat update of the sequencer
    always_comb
    begin
        phase_index_next = phase_index_reg;
        steps_left_next  = steps_left_reg;
        wait_count_next  = wait_count_reg;
        moving_next      = moving_reg;
        coil_levels_next = coil_levels_reg;
        strobe           = 1'b0;

        // count saturates to the counter maximum
        cnt_ext  = EXT_W'(step_count);
        // an interval of zero behaves as one
        lim      = (step_interval_reg == '0) ? WAIT_W'(1) : step_interval_reg;
        wait_inc = {1'b0, wait_count_reg} + 1'b1;

        case (operation)
            OP_START:
            begin
                steps_left_next  = (cnt_ext > CNT_MAX) ? COUNT_WIDTH'(CNT_MAX)
                                                       : COUNT_WIDTH'(cnt_ext);
                phase_index_next = '0;
                wait_count_next  = '0;
                moving_next      = (step_count != '0);
            end
            OP_STOP:
            begin
                moving_next = 1'b0;
            end
            OP_TICK:
            begin
                if (moving_reg && steps_left_reg != '0)
                begin
                    if (wait_inc >= {1'b0, lim})
                    begin
                        wait_count_next = '0;
                        for (int k = 0; k < 4; k++)
                        begin
                            coil_levels_next[k] = phase_level(step_mode_reg, clockwise_reg,
                                                              2'(k), phase_index_reg);
                        end
                        // half and micro walk the table backward for clockwise
                        if (step_mode_reg[1] && clockwise_reg)
                            phase_index_next = phase_index_reg - 1'b1;
                        else
                            phase_index_next = phase_index_reg + 1'b1;
                        strobe          = 1'b1;
                        steps_left_next = steps_left_reg - 1'b1;
                        if (steps_left_next == '0)
                            moving_next = 1'b0;
                    end
                    else
                    begin
                        wait_count_next = wait_inc[WAIT_W-1:0];
                    end
                end
            end
            default: ;
        endcase

        result.levels = coil_levels_next;
        result.strobe = strobe;
        result.busy   = moving_next && (steps_left_next != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_index_reg <= '0;
            steps_left_reg  <= '0;
            wait_count_reg  <= '0;
            moving_reg      <= 1'b0;
            coil_levels_reg <= '0;
        end
        else if (in_fire)
        begin
            phase_index_reg <= phase_index_next;
            steps_left_reg  <= steps_left_next;
            wait_count_reg  <= wait_count_next;
            moving_reg      <= moving_next;
            coil_levels_reg <= coil_levels_next;
        end
    end

    // output register with skid backup, order kept: skid drains first
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (in_fire)
            begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_fire)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid    = out_valid_reg;
    assign coil_a_level = out_data_reg.levels[0];
    assign coil_b_level = out_data_reg.levels[1];
    assign coil_c_level = out_data_reg.levels[2];
    assign coil_d_level = out_data_reg.levels[3];
    assign step_strobe  = out_data_reg.strobe;
    assign busy_res     = out_data_reg.busy;

endmodule

`default_nettype wire
